### rtl/cgt_pkg.sv
// Shared types and constants for the color gradient texture generator.
// Used by cgt_div, cgt_lane and color_gradient_texture_gen; depends on nothing.
package cgt_pkg;

  localparam int CHAN_W    = 8;
  localparam int STEPS_W   = 6;
  localparam int NUM_CHAN  = 3;
  localparam int CH_IDX_W  = 2;
  localparam int DIV_ITERS = CHAN_W;
  localparam int CNT_W     = 3;

  localparam logic [CH_IDX_W-1:0] CH_RED   = 2'd0;
  localparam logic [CH_IDX_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CH_IDX_W-1:0] CH_BLUE  = 2'd2;
  localparam logic [CH_IDX_W-1:0] CH_LAST  = CH_BLUE;

  localparam logic [STEPS_W-1:0] STEPS_RESET = 6'd1;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [STEPS_W-1:0] steps_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_TEXEL,
    ST_FINAL
  } cgt_state_t;

  typedef struct packed {
    logic   start;
    chan_t  dividend;
    steps_t divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    chan_t  quotient;
    steps_t remainder;
  } div_rsp_t;

  typedef struct packed {
    logic load;
    logic delta_we;
    logic step;
  } lane_ctrl_t;

endpackage

### rtl/cgt_div.sv
// Shared restoring divider: 8-bit dividend by 6-bit divisor, one bit per cycle.
// Depends on cgt_pkg for the request and response structs.
module cgt_div
  import cgt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  steps_t           rem_r;
  chan_t            quo_r;
  steps_t           dsr_r;

  logic [STEPS_W:0] trial;
  logic [STEPS_W:0] diff;
  logic             ge;

  // One long-division step: bring down the next dividend bit and try a subtract.
  assign trial = {rem_r, quo_r[CHAN_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[STEPS_W-1:0] : trial[STEPS_W-1:0];
      quo_r <= {quo_r[CHAN_W-2:0], ge};
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

### rtl/cgt_lane.sv
// One color channel of the gradient stepper: quotient and remainder accumulator.
// Depends on cgt_pkg for the lane control struct.
module cgt_lane
  import cgt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  lane_ctrl_t ctl,
  input  chan_t      load_val,
  input  chan_t      delta_q,
  input  steps_t     delta_r,
  input  steps_t     steps,
  output chan_t      value
);

  chan_t            val_r;
  steps_t           rem_r;
  chan_t            dq_r;
  steps_t           dr_r;

  logic [STEPS_W:0] sum;
  logic [STEPS_W:0] wrap;
  logic             carry;

  // Advancing by one texel adds the whole and fractional parts of the per-step
  // delta; a fractional overflow carries one into the color value.
  assign sum   = {1'b0, rem_r} + {1'b0, dr_r};
  assign carry = sum >= {1'b0, steps};
  assign wrap  = sum - {1'b0, steps};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val_r <= load_val;
      rem_r <= '0;
    end else if (ctl.step) begin
      val_r <= val_r + dq_r + {{(CHAN_W-1){1'b0}}, carry};
      rem_r <= carry ? wrap[STEPS_W-1:0] : sum[STEPS_W-1:0];
    end
    if (ctl.delta_we) begin
      dq_r <= delta_q;
      dr_r <= delta_r;
    end
  end

  assign value = val_r;

`ifndef ASSERT_OFF
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step |-> (rem_r < steps))
    else $error("lane remainder not below segment length");
`endif

endmodule

### rtl/color_gradient_texture_gen.sv
// Top level of the linear color gradient texture generator.
// Depends on cgt_pkg, cgt_div (shared divider) and cgt_lane (channel stepper).
//
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_stall    stop_red, stop_green, stop_blue, last_stop
// out_     output     out_valid / out_stall  texel_red, texel_green, texel_blue, last_texel
// cfg_     input      cfg_valid / cfg_ready  steps_per_segment (6 bits)
//
// Once a stop is accepted, if a previous stop is held and the segment length S
// is nonzero, the shared divider runs once per channel (issue, 8 quotient bits,
// result); then S texels follow at one per cycle while the output is not stalled,
// and a stop marked last adds one final texel.
// Reset (rst_n, synchronous, active low) sets S to 1 and forgets the previous stop.
// A stall on a waiting texel holds the texel register and pauses texel stepping. The
// input is stalled while the sequencer is busy; it opens again once the last texel
// of a stop has entered the output register, even if that texel is still waiting.
module color_gradient_texture_gen
  import cgt_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,

  input  logic   in_valid,
  output logic   in_stall,
  input  chan_t  in_stop_red,
  input  chan_t  in_stop_green,
  input  chan_t  in_stop_blue,
  input  logic   in_last_stop,

  output logic   out_valid,
  input  logic   out_stall,
  output chan_t  out_texel_red,
  output chan_t  out_texel_green,
  output chan_t  out_texel_blue,
  output logic   out_last_texel,

  input  logic   cfg_valid,
  output logic   cfg_ready,
  input  steps_t cfg_steps_per_segment
);

  cgt_state_t state_r, state_nxt;

  steps_t            steps_r;
  chan_t             prev_r [NUM_CHAN];
  logic              have_prev_r;
  chan_t             cur_r  [NUM_CHAN];
  logic              last_r;
  logic signed [CHAN_W:0] d_r [NUM_CHAN];
  logic [CH_IDX_W-1:0] ch_r;
  steps_t            j_r;

  logic              out_valid_r;
  chan_t             out_red_r;
  chan_t             out_green_r;
  chan_t             out_blue_r;
  logic              out_last_r;

  chan_t             in_col [NUM_CHAN];
  chan_t             lane_val [NUM_CHAN];
  lane_ctrl_t        lane_ctl [NUM_CHAN];

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              in_take;
  logic              slot_free;
  logic              emit_texel;
  logic              emit_final;
  logic              load_lanes;
  logic              step_lanes;
  logic              delta_we;

  logic signed [CHAN_W:0] d_sel;
  logic [CHAN_W:0]   d_mag;
  chan_t             delta_q;
  steps_t            delta_r;

  assign in_col[CH_RED]   = in_stop_red;
  assign in_col[CH_GREEN] = in_stop_green;
  assign in_col[CH_BLUE]  = in_stop_blue;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;

  // The divider works on the magnitude of the channel difference; a negative
  // difference is turned into a floor quotient with a nonnegative remainder.
  assign d_sel = d_r[ch_r];
  assign d_mag = d_sel[CHAN_W] ? ((CHAN_W+1)'(0) - d_sel) : d_sel;

  always_comb begin
    if (!d_sel[CHAN_W]) begin
      delta_q = div_rsp.quotient;
      delta_r = div_rsp.remainder;
    end else if (div_rsp.remainder == '0) begin
      delta_q = chan_t'(0) - div_rsp.quotient;
      delta_r = '0;
    end else begin
      delta_q = chan_t'(0) - div_rsp.quotient - chan_t'(1);
      delta_r = steps_r - div_rsp.remainder;
    end
  end

  // Sequencer: next state and per-cycle strobes.
  always_comb begin
    state_nxt       = state_r;
    div_req.start   = 1'b0;
    div_req.dividend = d_mag[CHAN_W-1:0];
    div_req.divisor = steps_r;
    emit_texel      = 1'b0;
    emit_final      = 1'b0;
    load_lanes      = 1'b0;
    step_lanes      = 1'b0;
    delta_we        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          load_lanes = 1'b1;
          if (have_prev_r && (steps_r != '0)) begin
            state_nxt = ST_DIV_START;
          end else if (in_last_stop && (steps_r != '0)) begin
            state_nxt = ST_FINAL;
          end
        end
      end
      ST_DIV_START: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          delta_we  = 1'b1;
          state_nxt = (ch_r == CH_LAST) ? ST_TEXEL : ST_DIV_START;
        end
      end
      ST_TEXEL: begin
        if (slot_free) begin
          emit_texel = 1'b1;
          step_lanes = 1'b1;
          if (j_r == steps_r - steps_t'(1)) begin
            state_nxt = last_r ? ST_FINAL : ST_IDLE;
          end
        end
      end
      ST_FINAL: begin
        if (slot_free) begin
          emit_final = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control state: segment length, previous-stop flag, counters, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r     <= STEPS_RESET;
      have_prev_r <= 1'b0;
      ch_r        <= CH_RED;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        steps_r <= cfg_steps_per_segment;
      end
      if (in_take) begin
        have_prev_r <= !in_last_stop;
        ch_r        <= CH_RED;
        j_r         <= '0;
      end
      if (delta_we && (ch_r != CH_LAST)) begin
        ch_r <= ch_r + 1'b1;
      end
      if (emit_texel) begin
        j_r <= j_r + 1'b1;
      end
      if (emit_texel || emit_final) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Stop colors and the texel output register.
  always_ff @(posedge clk) begin
    if (in_take) begin
      last_r <= in_last_stop;
      for (int c = 0; c < NUM_CHAN; c++) begin
        cur_r[c]  <= in_col[c];
        prev_r[c] <= in_col[c];
        d_r[c]    <= $signed({1'b0, in_col[c]}) - $signed({1'b0, prev_r[c]});
      end
    end
    if (emit_final) begin
      out_red_r   <= cur_r[CH_RED];
      out_green_r <= cur_r[CH_GREEN];
      out_blue_r  <= cur_r[CH_BLUE];
      out_last_r  <= 1'b1;
    end else if (emit_texel) begin
      out_red_r   <= lane_val[CH_RED];
      out_green_r <= lane_val[CH_GREEN];
      out_blue_r  <= lane_val[CH_BLUE];
      out_last_r  <= 1'b0;
    end
  end

  cgt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Each lane starts from the previous stop's channel value.
  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
    assign lane_ctl[c].load     = load_lanes;
    assign lane_ctl[c].step     = step_lanes;
    assign lane_ctl[c].delta_we = delta_we && (ch_r == CH_IDX_W'(c));

    cgt_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (lane_ctl[c]),
      .load_val (prev_r[c]),
      .delta_q  (delta_q),
      .delta_r  (delta_r),
      .steps    (steps_r),
      .value    (lane_val[c])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_texel_red   = out_red_r;
  assign out_texel_green = out_green_r;
  assign out_texel_blue  = out_blue_r;
  assign out_last_texel  = out_last_r;

`ifndef ASSERT_OFF
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV_WAIT))
    else $error("divider result arrived outside the wait state");
`endif

`ifndef ASSERT_OFF
  a_texel_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TEXEL) |-> (j_r < steps_r))
    else $error("texel index ran past the segment length");
`endif

`ifndef ASSERT_OFF
  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    emit_final |=> (out_valid_r && out_last_r && !have_prev_r))
    else $error("final texel without a last stop");
`endif

endmodule

### test/color_gradient_texture_gen_tb.sv
// Self-checking testbench for color_gradient_texture_gen: color stops in, gradient texels out.
// Depends on cgt_pkg and the color_gradient_texture_gen RTL; needs no files or arguments.
`timescale 1ns / 100ps

module color_gradient_texture_gen_tb;
  import cgt_pkg::*;

  // A stop and a texel share one layout: three channels plus an end-of-map flag.
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last;
  } texel_t;

  typedef texel_t stop_t;

  // One row of the directed table. A row may rewrite the segment length first. Rows marked
  // typed carry their results written out by hand (at most two); the rest use the predictor.
  typedef struct packed {
    logic       cfg_we;
    steps_t     cfg_val;
    stop_t      stop;
    logic       typed;
    logic [1:0] exp_n;
    texel_t     exp0;
    texel_t     exp1;
  } stop_row_t;

  localparam int RANDOM_STOPS   = 100;
  localparam int SETTLE_CYCLES  = 120;   // covers the longest stop, with margin
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  chan_t  in_stop_red;
  chan_t  in_stop_green;
  chan_t  in_stop_blue;
  logic   in_last_stop;
  logic   out_valid;
  logic   out_stall = 1'b0;
  chan_t  out_texel_red;
  chan_t  out_texel_green;
  chan_t  out_texel_blue;
  logic   out_last_texel;
  logic   cfg_valid;
  logic   cfg_ready;
  steps_t cfg_steps_per_segment;

  // Predictor state: the segment length and the stop that opens the next segment.
  steps_t    grad_steps = STEPS_RESET;
  stop_t     prev_color = '0;
  bit        prev_valid = 1'b0;
  texel_t    expected_texels[$];
  stop_row_t stop_rows[$];

  // The directed row being driven right now; the monitor reads it when the stop is taken.
  logic       row_typed = 1'b0;
  logic [1:0] row_exp_n = '0;
  texel_t     row_exp0  = '0;
  texel_t     row_exp1  = '0;

  int  mismatches  = 0;
  int  idle_cycles = 0;
  int  stall_left  = 0;
  bit  tx_calm     = 1'b0;
  bit  rx_calm     = 1'b0;

  color_gradient_texture_gen dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_stop_red           (in_stop_red),
    .in_stop_green         (in_stop_green),
    .in_stop_blue          (in_stop_blue),
    .in_last_stop          (in_last_stop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_texel_red         (out_texel_red),
    .out_texel_green       (out_texel_green),
    .out_texel_blue        (out_texel_blue),
    .out_last_texel        (out_last_texel),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_steps_per_segment (cfg_steps_per_segment)
  );

  always #10 clk = ~clk;

  function automatic texel_t rgb(input chan_t r, input chan_t g, input chan_t b,
                                 input logic l);
    return {r, g, b, l};
  endfunction

  // Mostly random channels, with the two extremes showing up often.
  function automatic chan_t rand_chan();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Idle lengths shared by both sides: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return $urandom_range(10, 30);
    if (roll < 4) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Exact integer blend of one channel at step j of a segment of length s.
  function automatic chan_t blend_chan(input int a, input int c, input int j, input int s);
    return chan_t'(((s - j) * a + j * c) / s);
  endfunction

  // Works out the texels one stop produces and moves the predictor to the next state.
  // With emit low only the state moves, for rows whose results are typed in the table.
  task automatic gradient_step(input stop_t st, input bit emit);
    texel_t t;
    int     s;
    int     j;
    s = int'(grad_steps);
    if (prev_valid && s != 0) begin
      for (j = 0; j < s; j++) begin
        t.red   = blend_chan(prev_color.red,   st.red,   j, s);
        t.green = blend_chan(prev_color.green, st.green, j, s);
        t.blue  = blend_chan(prev_color.blue,  st.blue,  j, s);
        t.last  = 1'b0;
        if (emit) expected_texels.push_back(t);
      end
    end
    // The closing stop repeats its own color as the flagged final texel, unless S is zero.
    if (st.last && s != 0 && emit) expected_texels.push_back(rgb(st.red, st.green, st.blue, 1'b1));
    prev_color = st;
    prev_valid = !st.last;
  endtask

  task automatic flag_mismatch(input string what, input texel_t want, input texel_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%s: expected r=%0d g=%0d b=%0d last=%0d, got r=%0d g=%0d b=%0d last=%0d",
               what, want.red, want.green, want.blue, want.last,
               got.red, got.green, got.blue, got.last);
  endtask

  task automatic check_texel(input texel_t got);
    texel_t want;
    if (expected_texels.size() == 0) begin
      flag_mismatch("texel with nothing expected", '0, got);
    end else begin
      want = expected_texels.pop_front();
      if (want.red != got.red || want.green != got.green || want.blue != got.blue ||
          want.last != got.last)
        flag_mismatch("texel mismatch", want, got);
    end
  endtask

  // Monitor: everything is sampled at the rising edge, before the block's own updates land.
  // The output check comes first so a texel and a new stop on the same edge stay in order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        check_texel(rgb(out_texel_red, out_texel_green, out_texel_blue, out_last_texel));
      if (in_valid && !in_stall) begin
        if (row_typed) begin
          if (row_exp_n > 0) expected_texels.push_back(row_exp0);
          if (row_exp_n > 1) expected_texels.push_back(row_exp1);
          gradient_step(rgb(in_stop_red, in_stop_green, in_stop_blue, in_last_stop), 1'b0);
        end else begin
          gradient_step(rgb(in_stop_red, in_stop_green, in_stop_blue, in_last_stop), 1'b1);
        end
      end
      if (cfg_valid && cfg_ready) grad_steps = cfg_steps_per_segment;
    end

    // Watchdog: a long run of cycles with no transaction on any channel means a hang.
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver back-pressure, changed on the falling edge. rx_calm turns it off for a stretch.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (!rx_calm) begin
      stall_left = pick_gap();
      out_stall  = (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Presents one stop from a falling edge and holds it until it is taken. Valid only drops
  // when a gap follows, so back-to-back stops keep it high.
  task automatic send_stop(input stop_t st);
    int gap;
    in_valid      = 1'b1;
    in_stop_red   = st.red;
    in_stop_green = st.green;
    in_stop_blue  = st.blue;
    in_last_stop  = st.last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drains the block: every expected texel must arrive, then a first stop of a map, which
  // produces nothing, gets time to finish before the register is touched.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_texels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_steps(input steps_t value);
    cfg_valid             = 1'b1;
    cfg_steps_per_segment = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_row(input logic cfg_we, input steps_t cfg_val, input stop_t st,
                         input logic typed, input logic [1:0] n, input texel_t e0,
                         input texel_t e1);
    stop_rows.push_back({cfg_we, cfg_val, st, typed, n, e0, e1});
  endtask

  initial begin
    int        i;
    int        k;
    int        map_len;
    int        items;
    stop_t     st;
    steps_t    s_new;
    stop_row_t row;

    rst_n                 = 1'b0;
    in_valid              = 1'b0;
    in_stop_red           = '0;
    in_stop_green         = '0;
    in_stop_blue          = '0;
    in_last_stop          = 1'b0;
    cfg_valid             = 1'b0;
    cfg_steps_per_segment = '0;

    // With S = 1 from reset a segment is just the previous stop, so results read off directly.
    add_row(0, 6'd0, rgb(255, 255, 255, 1), 1, 2'd1, rgb(255, 255, 255, 1), '0);
    add_row(0, 6'd0, rgb(0, 0, 0, 0), 1, 2'd0, '0, '0);
    add_row(0, 6'd0, rgb(255, 0, 128, 1), 1, 2'd2, rgb(0, 0, 0, 0), rgb(255, 0, 128, 1));
    add_row(0, 6'd0, rgb(8'hAA, 8'h55, 8'h0F, 0), 1, 2'd0, '0, '0);
    add_row(0, 6'd0, rgb(8'h55, 8'hAA, 8'hF0, 1), 1, 2'd2, rgb(8'hAA, 8'h55, 8'h0F, 0),
            rgb(8'h55, 8'hAA, 8'hF0, 1));
    // Longest segments: a full ramp up, then a ramp down that also ends the map.
    add_row(1, 6'd63, rgb(0, 0, 0, 0), 1, 2'd0, '0, '0);
    add_row(0, 6'd0, rgb(255, 255, 255, 0), 0, 2'd0, '0, '0);
    add_row(0, 6'd0, rgb(0, 0, 0, 1), 0, 2'd0, '0, '0);
    // Zero steps: no texels at all, not even the final one, but the stops still advance.
    add_row(1, 6'd0, rgb(1, 2, 3, 0), 1, 2'd0, '0, '0);
    add_row(0, 6'd0, rgb(4, 5, 6, 1), 1, 2'd0, '0, '0);
    add_row(0, 6'd0, rgb(7, 8, 9, 1), 1, 2'd0, '0, '0);
    // A lone closing stop gives just its own color; then an ordinary short map.
    add_row(1, 6'd2, rgb(200, 100, 50, 1), 1, 2'd1, rgb(200, 100, 50, 1), '0);
    add_row(0, 6'd0, rgb(0, 255, 0, 0), 1, 2'd0, '0, '0);
    add_row(0, 6'd0, rgb(255, 0, 255, 0), 0, 2'd0, '0, '0);
    add_row(0, 6'd0, rgb(17, 34, 51, 1), 0, 2'd0, '0, '0);
    // Dropping to zero steps in mid-map must still move the previous stop along.
    add_row(1, 6'd3, rgb(10, 20, 30, 0), 1, 2'd0, '0, '0);
    add_row(1, 6'd0, rgb(40, 50, 60, 0), 1, 2'd0, '0, '0);
    add_row(1, 6'd3, rgb(70, 80, 90, 1), 0, 2'd0, '0, '0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. Every register write waits for the block to drain first.
    for (i = 0; i < stop_rows.size(); i++) begin
      row = stop_rows[i];
      if (row.cfg_we) begin
        wait_idle();
        write_steps(row.cfg_val);
      end
      row_typed = row.typed;
      row_exp_n = row.exp_n;
      row_exp0  = row.exp0;
      row_exp1  = row.exp1;
      send_stop(row.stop);
    end
    row_typed = 1'b0;

    // Random part: mostly well-formed maps of one to five stops under changing segment
    // lengths (mostly short, sometimes 63 or zero), with an odd broken end-of-map flag.
    items = 0;
    while (items < RANDOM_STOPS) begin
      if (items == 0 || $urandom_range(0, 2) == 0) begin
        wait_idle();
        case ($urandom_range(0, 9))
          0:       s_new = 6'd0;
          1:       s_new = 6'd63;
          2, 3:    s_new = steps_t'($urandom_range(1, 63));
          default: s_new = steps_t'($urandom_range(1, 8));
        endcase
        write_steps(s_new);
      end
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      map_len = $urandom_range(1, 5);
      for (k = 0; k < map_len; k++) begin
        st = rgb(rand_chan(), rand_chan(), rand_chan(), k == map_len - 1);
        if ($urandom_range(0, 9) == 0) st.last = 1'($urandom_range(0, 1));
        send_stop(st);
        items++;
      end
      // Now and then the sender holds off until every expected texel has come back.
      if ($urandom_range(0, 5) == 0) begin
        in_valid = 1'b0;
        while (expected_texels.size() != 0) @(negedge clk);
      end
    end

    wait_idle();
    if (mismatches == 0 && expected_texels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### color_gradient_texture_gen.f
rtl/cgt_pkg.sv
rtl/cgt_div.sv
rtl/cgt_lane.sv
rtl/color_gradient_texture_gen.sv
test/color_gradient_texture_gen_tb.sv
